// ----- hdl/glass_tile_source_coordinate_defines.svh -----
// Assertion macros for the glass tile source coordinate block.
// Expects clk and rst_n in the scope of every use.
`ifndef GLASS_TILE_SOURCE_COORDINATE_DEFINES_SVH
`define GLASS_TILE_SOURCE_COORDINATE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GTSC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GTSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gtsc_pkg.sv -----
// Package for the glass tile source coordinate block.
// Register codes, reset values, configuration struct and the remainder step.
`default_nettype none

package gtsc_pkg;

    localparam int COORD_WIDTH_DEFAULT = 14;
    localparam int TILE_W              = 9;
    localparam int IMG_W               = 15;
    localparam int CFG_INDEX_W         = 4;
    localparam int CFG_DATA_W          = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_GLASS_W      = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_GLASS_H      = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = CFG_INDEX_W'(3);

    localparam logic [TILE_W-1:0] GLASS_W_RESET      = TILE_W'(25);
    localparam logic [TILE_W-1:0] GLASS_H_RESET      = TILE_W'(25);
    localparam logic [IMG_W-1:0]  IMAGE_WIDTH_RESET  = IMG_W'(1024);
    localparam logic [IMG_W-1:0]  IMAGE_HEIGHT_RESET = IMG_W'(1024);

    typedef struct packed {
        logic [TILE_W-1:0] glass_w;
        logic [TILE_W-1:0] glass_h;
        logic [IMG_W-1:0]  image_width;
        logic [IMG_W-1:0]  image_height;
    } cfg_t;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // Requires rem < size on entry; the result is again below size.
    function automatic logic [TILE_W-1:0] rem_step(
        input logic [TILE_W-1:0] rem,
        input logic              bit_in,
        input logic [TILE_W-1:0] size
    );
        logic [TILE_W:0] t;
        logic [TILE_W:0] d;
        t = {rem, bit_in};
        d = t - {1'b0, size};
        return (t >= {1'b0, size}) ? d[TILE_W-1:0] : t[TILE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gtsc_channels.sv -----
// Channel interfaces: pixel coordinate in, source coordinate out, register writes.
// Depends on gtsc_pkg.
`default_nettype none

interface gtsc_pixel_if
    import gtsc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) ();
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface gtsc_source_if
    import gtsc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) ();
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] source_x;
    logic [COORD_WIDTH-1:0] source_y;

    modport source (output valid, output source_x, output source_y, input ready);
    modport sink (input valid, input source_x, input source_y, output ready);
endinterface

interface gtsc_cfg_if
    import gtsc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/gtsc_rem_pipe.sv -----
// Pipelined restoring remainder: coordinate modulo tile size for both axes,
// one dividend bit per stage. Depends on gtsc_pkg and the assertion macros.
`default_nettype none
`include "glass_tile_source_coordinate_defines.svh"

module gtsc_rem_pipe
    import gtsc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] in_x,
    input  logic [COORD_WIDTH-1:0] in_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_WIDTH-1:0] out_x,
    output logic [COORD_WIDTH-1:0] out_y,
    output logic [TILE_W-1:0]      out_rem_x,
    output logic [TILE_W-1:0]      out_rem_y
);

    localparam int N = COORD_WIDTH;

    logic                   valid_reg [N];
    logic [N-1:0]           x_reg     [N];
    logic [N-1:0]           y_reg     [N];
    logic [TILE_W-1:0]      rx_reg    [N];
    logic [TILE_W-1:0]      ry_reg    [N];
    logic                   stage_ready [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic              prev_valid;
            logic [N-1:0]      prev_x;
            logic [N-1:0]      prev_y;
            logic [TILE_W-1:0] prev_rx;
            logic [TILE_W-1:0] prev_ry;
            logic              next_ready;

            if (k == 0)
            begin : g_first
                assign prev_valid = in_valid;
                assign prev_x     = in_x;
                assign prev_y     = in_y;
                assign prev_rx    = '0;
                assign prev_ry    = '0;
            end
            else
            begin : g_rest
                assign prev_valid = valid_reg[k-1];
                assign prev_x     = x_reg[k-1];
                assign prev_y     = y_reg[k-1];
                assign prev_rx    = rx_reg[k-1];
                assign prev_ry    = ry_reg[k-1];
            end

            if (k == N - 1)
            begin : g_last
                assign next_ready = out_ready;
            end
            else
            begin : g_mid
                assign next_ready = stage_ready[k+1];
            end

            assign stage_ready[k] = !valid_reg[k] || next_ready;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (stage_ready[k])
                begin
                    valid_reg[k] <= prev_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stage_ready[k] && prev_valid)
                begin
                    x_reg[k]  <= prev_x;
                    y_reg[k]  <= prev_y;
                    rx_reg[k] <= rem_step(prev_rx, prev_x[N-1-k], cfg.glass_w);
                    ry_reg[k] <= rem_step(prev_ry, prev_y[N-1-k], cfg.glass_h);
                end
            end
        end
    endgenerate

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[N-1];
    assign out_x     = x_reg[N-1];
    assign out_y     = y_reg[N-1];
    assign out_rem_x = rx_reg[N-1];
    assign out_rem_y = ry_reg[N-1];

    `GTSC_ASSERT_IMPLY(a_rem_x_below_tile, valid_reg[N-1] && (cfg.glass_w != '0),
        rx_reg[N-1] < cfg.glass_w, "x remainder not below tile width")
    `GTSC_ASSERT_IMPLY(a_rem_y_below_tile, valid_reg[N-1] && (cfg.glass_h != '0),
        ry_reg[N-1] < cfg.glass_h, "y remainder not below tile height")
    `GTSC_ASSERT_NEXT(a_last_stage_holds, valid_reg[N-1] && !out_ready,
        valid_reg[N-1] && $stable(rx_reg[N-1]) && $stable(x_reg[N-1]),
        "last remainder stage lost its item under stall")

endmodule

`default_nettype wire

// ----- hdl/gtsc_axis_map.sv -----
// Distortion and bound stages: source coordinate from remainder, then the
// image bound rules and field saturation. Depends on gtsc_pkg and the macros.
`default_nettype none
`include "glass_tile_source_coordinate_defines.svh"

module gtsc_axis_map
    import gtsc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] in_x,
    input  logic [COORD_WIDTH-1:0] in_y,
    input  logic [TILE_W-1:0]      in_rem_x,
    input  logic [TILE_W-1:0]      in_rem_y,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COORD_WIDTH-1:0] out_x,
    output logic [COORD_WIDTH-1:0] out_y
);

    localparam int W  = COORD_WIDTH;
    localparam int SW = COORD_WIDTH + 3;
    localparam int CW = (SW > IMG_W + 1) ? SW : IMG_W + 1;

    // pos + off, less size when the offset wraps to the next centre
    function automatic logic signed [SW-1:0] distort(
        input logic [W-1:0]      pos,
        input logic [TILE_W-1:0] rem,
        input logic [TILE_W-1:0] size
    );
        logic wrap;
        wrap = rem >= (size >> 1);
        if (size == '0)
        begin
            return $signed(SW'(pos));
        end
        return $signed(SW'(pos) + SW'(rem) - (wrap ? SW'(size) : SW'(0)));
    endfunction

    function automatic logic [W-1:0] clamp_field(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] max_c;
        max_c = $signed(CW'({W{1'b1}}));
        if (v < $signed(CW'(0)))
        begin
            return '0;
        end
        if (v > max_c)
        begin
            return {W{1'b1}};
        end
        return v[W-1:0];
    endfunction

    logic                 va_reg;
    logic [W-1:0]         pxa_reg;
    logic signed [SW-1:0] sxa_reg;
    logic signed [SW-1:0] sya_reg;
    logic                 vb_reg;
    logic [W-1:0]         out_x_reg;
    logic [W-1:0]         out_y_reg;
    logic                 ready_a;
    logic                 ready_b;

    logic signed [CW-1:0] sx_c;
    logic signed [CW-1:0] sy_c;
    logic signed [CW-1:0] iw_c;
    logic signed [CW-1:0] ih_c;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic [W-1:0]         out_x_next;
    logic [W-1:0]         out_y_next;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                va_reg <= in_valid;
            end
            if (ready_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            pxa_reg <= in_x;
            sxa_reg <= distort(in_x, in_rem_x, cfg.glass_w);
            sya_reg <= distort(in_y, in_rem_y, cfg.glass_h);
        end
        if (ready_b && va_reg)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    always_comb
    begin
        sx_c = CW'(sxa_reg);
        sy_c = CW'(sya_reg);
        iw_c = $signed(CW'(cfg.image_width));
        ih_c = $signed(CW'(cfg.image_height));
        xs   = (sx_c >= iw_c) ? $signed(CW'(pxa_reg)) : sx_c;
        ys   = (sy_c >= ih_c) ? ih_c - $signed(CW'(1)) : sy_c;
        out_x_next = clamp_field(xs);
        out_y_next = clamp_field(ys);
    end

    assign out_valid = vb_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

    `GTSC_ASSERT_IMPLY(a_row_inside_image, vb_reg && (cfg.image_height != '0),
        CW'(out_y_reg) < CW'(cfg.image_height), "source row outside image")
    `GTSC_ASSERT_IMPLY(a_flat_x_passes, va_reg && (cfg.glass_w == '0),
        sxa_reg == $signed(SW'(pxa_reg)), "zero tile width changed x")
    `GTSC_ASSERT_NEXT(a_stage_a_holds, va_reg && !ready_b,
        va_reg && $stable(sxa_reg) && $stable(sya_reg), "stage A lost its item under stall")

endmodule

`default_nettype wire

// ----- hdl/glass_tile_source_coordinate.sv -----
// Glass tile source coordinate: maps each output pixel (pixel_x, pixel_y) to
// the source pixel that a glass tile distortion copies. One transfer is taken
// per cycle with no gaps while the output does not stall; a result passes the
// COORD_WIDTH-stage restoring remainder pipeline, then one distortion stage
// and one bound stage, each of them registered.
// Output stalls hold the pipeline without loss.
// Registers are written through cfg (always ready): index 0 tile width,
// 1 tile height, 2 image width, 3 image height; other indexes are ignored.
// Write them only while no transfer is in flight.
`default_nettype none

module glass_tile_source_coordinate
    import gtsc_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    gtsc_pixel_if.sink     pixel,
    gtsc_source_if.source  source,
    gtsc_cfg_if.sink       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic                   rem_valid;
    logic                   rem_ready;
    logic [COORD_WIDTH-1:0] rem_x;
    logic [COORD_WIDTH-1:0] rem_y;
    logic [TILE_W-1:0]      rem_off_x;
    logic [TILE_W-1:0]      rem_off_y;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_GLASS_W:      cfg_next.glass_w      = cfg.data[TILE_W-1:0];
                CFG_GLASS_H:      cfg_next.glass_h      = cfg.data[TILE_W-1:0];
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg.data[IMG_W-1:0];
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg.data[IMG_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glass_w      <= GLASS_W_RESET;
            cfg_reg.glass_h      <= GLASS_H_RESET;
            cfg_reg.image_width  <= IMAGE_WIDTH_RESET;
            cfg_reg.image_height <= IMAGE_HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gtsc_rem_pipe #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_rem_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .in_x      (pixel.pixel_x),
        .in_y      (pixel.pixel_y),
        .out_valid (rem_valid),
        .out_ready (rem_ready),
        .out_x     (rem_x),
        .out_y     (rem_y),
        .out_rem_x (rem_off_x),
        .out_rem_y (rem_off_y)
    );

    gtsc_axis_map #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_axis_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (rem_valid),
        .in_ready  (rem_ready),
        .in_x      (rem_x),
        .in_y      (rem_y),
        .in_rem_x  (rem_off_x),
        .in_rem_y  (rem_off_y),
        .out_valid (source.valid),
        .out_ready (source.ready),
        .out_x     (source.source_x),
        .out_y     (source.source_y)
    );

endmodule

`default_nettype wire

// ----- bench/glass_tile_source_coordinate_test.sv -----
// Testbench for glass_tile_source_coordinate: drives pixel transfers and register
// writes, predicts each source coordinate and checks every result in order.
// Depends on gtsc_pkg, gtsc_channels and the block itself.
`default_nettype none

module glass_tile_source_coordinate_test
    import gtsc_pkg::*;
();

    localparam int CW        = COORD_WIDTH_DEFAULT;
    localparam int COORD_TOP = (1 << CW) - 1;
    localparam int LATENCY   = CW + 2;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
    } src_coord_t;

    class coord_scoreboard;
        logic [TILE_W-1:0] tile_w;
        logic [TILE_W-1:0] tile_h;
        logic [IMG_W-1:0]  img_w;
        logic [IMG_W-1:0]  img_h;
        src_coord_t        pending[$];
        int                errors;

        function new();
            tile_w = GLASS_W_RESET;
            tile_h = GLASS_H_RESET;
            img_w  = IMAGE_WIDTH_RESET;
            img_h  = IMAGE_HEIGHT_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GLASS_W:      tile_w = data[TILE_W-1:0];
                CFG_GLASS_H:      tile_h = data[TILE_W-1:0];
                CFG_IMAGE_WIDTH:  img_w  = data[IMG_W-1:0];
                CFG_IMAGE_HEIGHT: img_h  = data[IMG_W-1:0];
                default: ;
            endcase
        endfunction

        // Tile-centered offset doubled; offsets at or past half a tile fold to the next center.
        function int distort_axis(int pos, int size);
            int off;
            int centre;
            if (size <= 0)
                return pos;
            off    = pos % size;
            centre = pos - off;
            if (off >= size / 2)
            begin
                centre += size;
                off    -= size;
            end
            return centre + 2 * off;
        endfunction

        function logic [CW-1:0] sat_coord(int v);
            if (v < 0)
                return '0;
            if (v > COORD_TOP)
                return CW'(COORD_TOP);
            return CW'(v);
        endfunction

        function void note_pixel(logic [CW-1:0] px, logic [CW-1:0] py);
            int         sx;
            int         sy;
            src_coord_t e;
            sx = distort_axis(int'(px), int'(tile_w));
            sy = distort_axis(int'(py), int'(tile_h));
            if (sx >= int'(img_w))
                sx = int'(px);
            if (sx < 0)
                sx = 0;
            if (sy >= int'(img_h))
                sy = int'(img_h) - 1;
            if (sy < 0)
                sy = 0;
            e.x = sat_coord(sx);
            e.y = sat_coord(sy);
            pending.push_back(e);
        endfunction

        function void check_source(logic [CW-1:0] sx, logic [CW-1:0] sy);
            src_coord_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result source_x %0d source_y %0d", sx, sy);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (sx !== e.x)
            begin
                $error("source_x expected %0d got %0d", e.x, sx);
                errors++;
            end
            if (sy !== e.y)
            begin
                $error("source_y expected %0d got %0d", e.y, sy);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;

    coord_scoreboard sb;

    gtsc_pixel_if  #(.COORD_WIDTH(CW)) pixel_ch ();
    gtsc_source_if #(.COORD_WIDTH(CW)) source_ch ();
    gtsc_cfg_if                        cfg_ch ();

    glass_tile_source_coordinate #(.COORD_WIDTH(CW)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_ch),
        .source (source_ch),
        .cfg    (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    // Transfer monitor: both channels sampled at the edge that completes them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_ch.valid && pixel_ch.ready)
                sb.note_pixel(pixel_ch.pixel_x, pixel_ch.pixel_y);
            if (source_ch.valid && source_ch.ready)
                sb.check_source(source_ch.source_x, source_ch.source_y);
        end
    end

    // Result side: random stall before each transfer.
    initial
    begin
        int stall;
        source_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                source_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            source_ch.ready <= 1'b1;
            @(posedge clk);
            while (!source_ch.valid)
                @(posedge clk);
        end
    end

    task automatic send_pixel(int px, int py);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_ch.valid   <= 1'b1;
        pixel_ch.pixel_x <= CW'(px);
        pixel_ch.pixel_y <= CW'(py);
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_drain();
        int cycles;
        cycles = 0;
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0 && cycles < 20000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Bits above the register width carry random junk; the block must drop them.
    // Valid stays high so writes can follow back to back; the caller drops it.
    task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, int value, int width);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data = (data & ~((CFG_DATA_W'(1) << width) - CFG_DATA_W'(1))) | CFG_DATA_W'(value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    function int pick_coord(int tile, int bound);
        int v;
        int k;
        case ($urandom_range(0, 4))
            0, 1: v = $urandom_range(0, COORD_TOP);
            2: v = $urandom_range(0, (bound < COORD_TOP - 64) ? bound + 64 : COORD_TOP);
            3:
            begin
                k = (tile > 0) ? $urandom_range(0, COORD_TOP / tile) : 0;
                v = k * tile + tile / 2 + $urandom_range(0, 4) - 2;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = COORD_TOP;
                    2: v = bound - 1;
                    default: v = bound;
                endcase
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > COORD_TOP)
            v = COORD_TOP;
        return v;
    endfunction

    task automatic run_phase(int tw, int th, int iw, int ih, int count);
        int i;
        wait_drain();
        write_cfg(CFG_GLASS_W, tw, TILE_W);
        write_cfg(CFG_GLASS_H, th, TILE_W);
        write_cfg(CFG_IMAGE_WIDTH, iw, IMG_W);
        write_cfg(CFG_IMAGE_HEIGHT, ih, IMG_W);
        cfg_ch.valid <= 1'b0;
        for (i = 0; i < count; i++)
        begin
            no_idle = (i < count / 5);
            if (i == count / 2)
                wait_drain();
            send_pixel(pick_coord(tw, iw), pick_coord(th, ih));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        int p;
        int tw;
        int th;
        int iw;
        int ih;
        sb                 = new();
        no_idle            = 1'b0;
        rst_n             <= 1'b0;
        pixel_ch.valid    <= 1'b0;
        pixel_ch.pixel_x  <= '0;
        pixel_ch.pixel_y  <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= '0;
        cfg_ch.data       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: tile 25, image 1024.
        send_pixel(0, 0);
        send_pixel(COORD_TOP, COORD_TOP);
        send_pixel(0, COORD_TOP);
        send_pixel(COORD_TOP, 0);
        send_pixel(12, 12);
        send_pixel(11, 11);
        send_pixel(13, 13);
        send_pixel(24, 24);
        send_pixel(25, 25);
        send_pixel(1023, 1023);
        send_pixel(1024, 1024);
        send_pixel(1036, 1036);
        send_pixel(1035, 1034);
        send_pixel(1011, 1022);
        send_pixel(37, 4096);
        send_pixel(16375, 16380);
        send_pixel(5461, 10922);
        no_idle = 1'b1;
        send_pixel(100, 200);
        send_pixel(101, 201);
        send_pixel(112, 212);
        no_idle = 1'b0;

        wait_drain();
        write_cfg(CFG_IMAGE_HEIGHT + CFG_INDEX_W'(1 + $urandom_range(0, 11)),
                  $urandom_range(0, 65535), CFG_DATA_W);
        cfg_ch.valid <= 1'b0;
        send_pixel(12, 1036);
        send_pixel(1036, 12);

        run_phase(5, 5, 16384, 16384, 140);
        run_phase(500, 500, 16384, 16384, 140);
        run_phase(0, 0, 1, 1, 140);
        run_phase(1, 2, 0, 0, 140);
        run_phase(3, 4, 32767, 32767, 140);
        run_phase(511, 7, 100, 50, 140);
        for (p = 0; p < 6; p++)
        begin
            tw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 500);
            th = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 500);
            iw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 16384);
            ih = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 16384);
            run_phase(tw, th, iw, ih, 150);
        end

        wait_drain();
        if (sb.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
